// ===== hw/rtl/rth_pkg.sv =====
// Package for the RGB to HSV converter: request types, constants and the
// divider step shared by the pipeline. No dependencies.
package rth_pkg;

  localparam int ChanW = 8;
  localparam int HueW = 9;
  localparam int StepBits = 2;
  localparam int DivStages = ChanW / StepBits;
  localparam int NumStages = 1 + DivStages;

  localparam logic [HueW-1:0] DegGreen = HueW'(120);
  localparam logic [HueW-1:0] DegBlue = HueW'(240);
  localparam logic [HueW-1:0] DegFull = HueW'(360);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [HueW-1:0] hue_deg;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] value_level;
    logic hue_defined;
  } hsv_t;

  typedef enum logic [2:0] {
    SEC_RED = 3'b001,
    SEC_GREEN = 3'b010,
    SEC_BLUE = 3'b100
  } sector_t;

  typedef struct packed {
    logic [ChanW-1:0] rem;
    logic [ChanW-1:0] num_low;
    logic [ChanW-1:0] den;
    logic [ChanW-1:0] quo;
  } div_t;

  typedef struct packed {
    div_t sat_div;
    div_t hue_div;
    logic [ChanW-1:0] value_level;
    sector_t sector;
    logic neg;
    logic defined;
    logic grey;
  } stg_t;

  // Restoring division, StepBits quotient bits per call. The remainder
  // always stays below the divisor, so it fits in ChanW bits.
  function automatic div_t div_step(div_t d);
    logic [ChanW:0] trial;
    div_t n;
    n = d;
    for (int i = 0; i < StepBits; i++) begin
      trial = {n.rem, n.num_low[ChanW-1]};
      n.num_low = {n.num_low[ChanW-2:0], 1'b0};
      n.quo = {n.quo[ChanW-2:0], 1'b0};
      if (trial >= {1'b0, n.den}) begin
        trial = trial - {1'b0, n.den};
        n.quo[0] = 1'b1;
      end
      n.rem = trial[ChanW-1:0];
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/rth_if.sv =====
// Valid/ready channel interfaces for the RGB to HSV converter.
// Depends on rth_pkg for the payload types.
interface rth_rgb_if;
  import rth_pkg::*;
  logic valid;
  logic ready;
  rgb_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rth_hsv_if;
  import rth_pkg::*;
  logic valid;
  logic ready;
  hsv_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rgb_to_hsv.sv =====
// RGB to HSV converter, top level: front end, pipelined dividers, output.
// Depends on rth_pkg and the channel interfaces in rth_if.sv.
//
// Usage: pixel_in carries one 8-bit RGB pixel per request, hsv_out one
// result per pixel with hue in degrees, saturation, value and a flag that
// is low for a black pixel. Both channels use valid/ready; a request moves
// when both are high.
// Throughput is one pixel per cycle while hsv_out is ready: one stage finds
// max, min, sector and the two numerators, four stages each produce two
// quotient bits of both divisions, and the output register forms hue and
// saturation.
// Each stage holds a valid bit; a stage loads when it is empty or when the
// stage after it moves on, so bubbles close up and a stalled receiver holds
// the output while the pipeline keeps filling. Nothing is lost or repeated.
// Reset clears all valid bits; no pixel is in flight afterwards.
module rgb_to_hsv (
  input logic clk,
  input logic rst,
  rth_rgb_if.sink pixel_in,
  rth_hsv_if.source hsv_out
);
  import rth_pkg::*;

  stg_t front;
  stg_t pipe [NumStages];
  logic valid [NumStages];
  logic en [NumStages];
  logic out_en;
  logic out_valid;
  hsv_t out_data;
  hsv_t out_next;

  logic [ChanW-1:0] r, g, b, mx, mn, delta, minuend, subtrahend, abs_diff;
  logic [2*ChanW-1:0] num_sat, num_hue;

  always_comb begin
    r = pixel_in.data.red;
    g = pixel_in.data.green;
    b = pixel_in.data.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    if (r == mx) begin
      front.sector = SEC_RED;
      minuend = g;
      subtrahend = b;
    end else if (g == mx) begin
      front.sector = SEC_GREEN;
      minuend = b;
      subtrahend = r;
    end else begin
      front.sector = SEC_BLUE;
      minuend = r;
      subtrahend = g;
    end
    front.neg = minuend < subtrahend;
    abs_diff = front.neg ? (subtrahend - minuend) : (minuend - subtrahend);
    num_sat = {delta, {ChanW{1'b0}}} - {{ChanW{1'b0}}, delta};
    num_hue = ({{ChanW{1'b0}}, abs_diff} << 6) - ({{ChanW{1'b0}}, abs_diff} << 2);
    front.sat_div = '{rem: num_sat[2*ChanW-1:ChanW], num_low: num_sat[ChanW-1:0],
                      den: mx, quo: '0};
    front.hue_div = '{rem: num_hue[2*ChanW-1:ChanW], num_low: num_hue[ChanW-1:0],
                      den: delta, quo: '0};
    front.value_level = mx;
    front.defined = mx != '0;
    front.grey = delta == '0;
  end

  always_comb begin
    out_en = !out_valid || hsv_out.ready;
    en[NumStages-1] = !valid[NumStages-1] || out_en;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign pixel_in.ready = en[0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pipe[0] <= front;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        pipe[k].sat_div <= div_step(pipe[k-1].sat_div);
        pipe[k].hue_div <= div_step(pipe[k-1].hue_div);
        pipe[k].value_level <= pipe[k-1].value_level;
        pipe[k].sector <= pipe[k-1].sector;
        pipe[k].neg <= pipe[k-1].neg;
        pipe[k].defined <= pipe[k-1].defined;
        pipe[k].grey <= pipe[k-1].grey;
      end
    end
    if (out_en) begin
      out_data <= out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumStages; k++) begin
        valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      if (en[0]) begin
        valid[0] <= pixel_in.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
      if (out_en) begin
        out_valid <= valid[NumStages-1];
      end
    end
  end

  stg_t last;
  logic [HueW-1:0] quo_hue, offset, hue;

  always_comb begin
    last = pipe[NumStages-1];
    quo_hue = {{(HueW-ChanW){1'b0}}, last.hue_div.quo};
    case (last.sector)
      SEC_RED: offset = '0;
      SEC_GREEN: offset = DegGreen;
      SEC_BLUE: offset = DegBlue;
      default: offset = '0;
    endcase
    if (!last.neg) begin
      hue = offset + quo_hue;
    end else if (offset < quo_hue) begin
      hue = offset + DegFull - quo_hue;
    end else begin
      hue = offset - quo_hue;
    end
    out_next.hue_deg = (last.defined && !last.grey) ? hue : '0;
    out_next.saturation = last.defined ? last.sat_div.quo : '0;
    out_next.value_level = last.value_level;
    out_next.hue_defined = last.defined;
  end

  assign hsv_out.valid = out_valid;
  assign hsv_out.data = out_data;

endmodule
